// ===== rtl/b5sp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b5sp_pkg
// Shared types, constants and symbol decode for the base-5 sequence packer.
// ----------------------------------------------------------------------------
package b5sp_pkg;

   // Width of the shared arithmetic unit; holds 5 * (2^32 - 1) plus a digit.
   localparam int unsigned ACC_W = 36;
   localparam int unsigned DIG_W = 3;

   localparam logic [31:0] TOP32 = 32'hFFFF_FFFF;

   // Action codes
   localparam logic [1:0] ACT_APPEND_NIB = 2'd0;
   localparam logic [1:0] ACT_APPEND_LET = 2'd1;
   localparam logic [1:0] ACT_CONCAT     = 2'd2;
   localparam logic [1:0] ACT_LOAD       = 2'd3;

   // Base digits
   localparam logic [DIG_W-1:0] DIG_N = 3'd0;
   localparam logic [DIG_W-1:0] DIG_A = 3'd1;
   localparam logic [DIG_W-1:0] DIG_C = 3'd2;
   localparam logic [DIG_W-1:0] DIG_G = 3'd3;
   localparam logic [DIG_W-1:0] DIG_T = 3'd4;

   // One-hot nibble codes
   localparam logic [7:0] NIB_A = 8'd1;
   localparam logic [7:0] NIB_C = 8'd2;
   localparam logic [7:0] NIB_G = 8'd4;
   localparam logic [7:0] NIB_T = 8'd8;

   // Upper-case ASCII letters
   localparam logic [7:0] CHR_A = 8'h41;
   localparam logic [7:0] CHR_C = 8'h43;
   localparam logic [7:0] CHR_G = 8'h47;
   localparam logic [7:0] CHR_T = 8'h54;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  base_symbol;
      logic [31:0] packed_operand;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] packed_value;
      logic        is_length_only;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPEND,
      ST_CNT_RUN,
      ST_CNT_OPND,
      ST_JOIN,
      ST_SHIFT,
      ST_FINISH
   } state_type;

   // How the finisher turns the accumulator into a packed value
   typedef enum logic [1:0] {
      FIN_PLAIN,     // saturate to 32 bits
      FIN_CLAMP,     // short append: overflow becomes length limit + 1
      FIN_LONGSUM    // both long: subtract the cut, then saturate
   } fin_mode_type;

   typedef enum logic {
      UOP_ADD,       // a + b
      UOP_MUL5       // a * 5 + b
   } unit_op_type;

   typedef struct packed {
      unit_op_type      op;
      logic [ACC_W-1:0] a;
      logic [ACC_W-1:0] b;
   } unit_req_type;

   // Largest value held in 'limit' base-5 digits; elaboration use only.
   function automatic logic [31:0] cut_of(int unsigned limit);
      logic [31:0] p;
      p = 32'd1;
      for (int unsigned i = 0; i < limit; i++) begin
         p = p * 32'd5;
      end
      return p - 32'd1;
   endfunction

   function automatic logic [DIG_W-1:0] nibble_digit(logic [7:0] code);
      logic [DIG_W-1:0] d;
      case (code)
         NIB_A:   d = DIG_A;
         NIB_C:   d = DIG_C;
         NIB_G:   d = DIG_G;
         NIB_T:   d = DIG_T;
         default: d = DIG_N;
      endcase
      return d;
   endfunction

   function automatic logic [DIG_W-1:0] letter_digit(logic [7:0] ch);
      logic [DIG_W-1:0] d;
      case (ch)
         CHR_A:   d = DIG_A;
         CHR_C:   d = DIG_C;
         CHR_G:   d = DIG_G;
         CHR_T:   d = DIG_T;
         default: d = DIG_N;
      endcase
      return d;
   endfunction

endpackage

// ===== rtl/b5sp_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b5sp_unit
// Shared multiply-by-five and add unit, reused every sequencer step.
// ----------------------------------------------------------------------------
module b5sp_unit (
   input  b5sp_pkg::unit_req_type                req,
   output logic [b5sp_pkg::ACC_W-1:0]            y
);
   import b5sp_pkg::*;

   logic [ACC_W-1:0] times5;

   assign times5 = (req.a << 2) + req.a;

   always_comb begin
      unique case (req.op)
         UOP_MUL5: y = times5 + req.b;
         UOP_ADD:  y = req.a + req.b;
         default:  y = req.a + req.b;
      endcase
   end

endmodule

// ===== rtl/b5sp_finish.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b5sp_finish
// Turns the accumulator into the 32-bit packed result and its long-form flag.
// ----------------------------------------------------------------------------
module b5sp_finish #(
   parameter int unsigned LEN_LIMIT = 13
) (
   input  logic [b5sp_pkg::ACC_W-1:0]  acc,
   input  b5sp_pkg::fin_mode_type      mode,
   output b5sp_pkg::rsp_payload_type   res
);
   import b5sp_pkg::*;

   localparam logic [31:0] CUT = cut_of(LEN_LIMIT);

   logic [ACC_W-1:0] sat_src;
   logic [31:0]      sat_val;
   logic [31:0]      val;

   // long + long arrives as run + operand; take the cut back out
   assign sat_src = (mode == FIN_LONGSUM) ? (acc - ACC_W'(CUT)) : acc;
   assign sat_val = (sat_src > ACC_W'(TOP32)) ? TOP32 : sat_src[31:0];

   always_comb begin
      unique case (mode)
         FIN_PLAIN:   val = sat_val;
         FIN_LONGSUM: val = sat_val;
         FIN_CLAMP:   val = (acc > ACC_W'(CUT)) ? (CUT + 32'(LEN_LIMIT)) : acc[31:0];
         default:     val = acc[31:0];
      endcase
   end

   assign res.packed_value   = val;
   assign res.is_length_only = (val > CUT);

endmodule

// ===== rtl/base5_sequence_packer_core.sv =====
`timescale 1ns / 1ps
// A load goes straight to the finish step and an append passes through the append
//   step. A concatenate counts the digits of the running value if it is short and
//   of the operand if it is short, joins them, and shifts by the operand's digits
//   if both are short and fitting. A new request is taken only in idle; every
//   digit step goes through the single multiply-by-five adder. Synchronous active-high
//   reset empties the running sequence (zero) and drops any pending result.
// ----------------------------------------------------------------------------
// base5_sequence_packer_core
// Running base-5 packed DNA sequence: append, concatenate and load actions.
// ----------------------------------------------------------------------------
module base5_sequence_packer_core #(
   parameter int unsigned LEN_LIMIT = 13
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  b5sp_pkg::req_payload_type  req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output b5sp_pkg::rsp_payload_type  rsp_data
);
   import b5sp_pkg::*;

   // Cut point: values above it are the length-only long form.
   localparam logic [31:0] CUT   = cut_of(LEN_LIMIT);
   localparam int unsigned CNT_W = $clog2(LEN_LIMIT + 1);

   // Sequencer state and working registers
   state_type          state_ff,     state_in;
   logic [31:0]        run_ff,       run_in;        // running packed value
   logic [ACC_W-1:0]   acc_ff,       acc_in;        // power of five / partial result
   logic [CNT_W-1:0]   ls_ff,        ls_in;         // digits in running value
   logic [CNT_W-1:0]   lo_ff,        lo_in;         // digits in operand, then shift count
   fin_mode_type       mode_ff,      mode_in;
   logic [31:0]        opnd_ff,      opnd_in;
   logic [DIG_W-1:0]   digit_ff,     digit_in;
   logic               run_long_ff,  run_long_in;
   logic               opnd_long_ff, opnd_long_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff,  rsp_data_in;

   unit_req_type       unit_req;
   logic [ACC_W-1:0]   unit_y;
   rsp_payload_type    fin_res;
   logic [CNT_W:0]     len_sum;
   logic               rsp_load;

   b5sp_unit u_unit (
      .req (unit_req),
      .y   (unit_y)
   );

   b5sp_finish #(
      .LEN_LIMIT (LEN_LIMIT)
   ) u_finish (
      .acc  (acc_ff),
      .mode (mode_ff),
      .res  (fin_res)
   );

   assign len_sum = {1'b0, ls_ff} + {1'b0, lo_ff};

   // ------------------------------------------------------------------------
   // Sequencer: next state and datapath control
   // ------------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      ls_in        = ls_ff;
      lo_in        = lo_ff;
      mode_in      = mode_ff;
      opnd_in      = opnd_ff;
      digit_in     = digit_ff;
      run_long_in  = run_long_ff;
      opnd_long_in = opnd_long_ff;
      unit_req.op  = UOP_ADD;
      unit_req.a   = ACC_W'(run_ff);
      unit_req.b   = '0;
      req_ready    = 1'b0;
      rsp_load     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               opnd_in      = req_data.packed_operand;
               digit_in     = (req_data.action == ACT_APPEND_NIB) ?
                              nibble_digit(req_data.base_symbol) :
                              letter_digit(req_data.base_symbol);
               run_long_in  = (run_ff > CUT);
               opnd_long_in = (req_data.packed_operand > CUT);
               ls_in        = '0;
               lo_in        = '0;
               acc_in       = ACC_W'(1);   // first power of five for digit counting
               unique case (req_data.action) inside
                  ACT_APPEND_NIB, ACT_APPEND_LET: begin
                     state_in = ST_APPEND;
                  end
                  ACT_CONCAT: begin
                     if (!run_long_in) begin
                        state_in = ST_CNT_RUN;
                     end else if (!opnd_long_in) begin
                        state_in = ST_CNT_OPND;
                     end else begin
                        state_in = ST_JOIN;
                     end
                  end
                  default: begin   // load takes the operand as is
                     acc_in   = ACC_W'(req_data.packed_operand);
                     mode_in  = FIN_PLAIN;
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end

         ST_APPEND: begin
            if (run_long_ff) begin
               // long form just grows by one base
               unit_req.op = UOP_ADD;
               unit_req.b  = ACC_W'(1);
               mode_in     = FIN_PLAIN;
            end else begin
               unit_req.op = UOP_MUL5;
               unit_req.b  = ACC_W'(digit_ff);
               mode_in     = FIN_CLAMP;
            end
            acc_in   = unit_y;
            state_in = ST_FINISH;
         end

         ST_CNT_RUN: begin
            // count digits: raise the power of five until it exceeds the value
            if (acc_ff <= ACC_W'(run_ff)) begin
               unit_req.op = UOP_MUL5;
               unit_req.a  = acc_ff;
               acc_in      = unit_y;
               ls_in       = ls_ff + CNT_W'(1);
            end else if (!opnd_long_ff) begin
               acc_in   = ACC_W'(1);
               state_in = ST_CNT_OPND;
            end else begin
               state_in = ST_JOIN;
            end
         end

         ST_CNT_OPND: begin
            if (acc_ff <= ACC_W'(opnd_ff)) begin
               unit_req.op = UOP_MUL5;
               unit_req.a  = acc_ff;
               acc_in      = unit_y;
               lo_in       = lo_ff + CNT_W'(1);
            end else begin
               state_in = ST_JOIN;
            end
         end

         ST_JOIN: begin
            unit_req.op = UOP_ADD;
            mode_in     = FIN_PLAIN;
            state_in    = ST_FINISH;
            if (run_long_ff && opnd_long_ff) begin
               unit_req.b = ACC_W'(opnd_ff);
               mode_in    = FIN_LONGSUM;
            end else if (run_long_ff) begin
               unit_req.b = ACC_W'(lo_ff);
            end else if (opnd_long_ff) begin
               unit_req.a = ACC_W'(opnd_ff);
               unit_req.b = ACC_W'(ls_ff);
            end else if (len_sum > (CNT_W + 1)'(LEN_LIMIT)) begin
               // too long together: length-only form of the combined length
               unit_req.a = ACC_W'(CUT);
               unit_req.b = ACC_W'(len_sum - (CNT_W + 1)'(1));
            end else begin
               state_in = ST_SHIFT;   // acc takes the running value
            end
            acc_in = unit_y;
         end

         ST_SHIFT: begin
            unit_req.a = acc_ff;
            if (lo_ff != '0) begin
               unit_req.op = UOP_MUL5;   // shift up one digit
               lo_in       = lo_ff - CNT_W'(1);
            end else begin
               unit_req.op = UOP_ADD;
               unit_req.b  = ACC_W'(opnd_ff);
               mode_in     = FIN_PLAIN;
               state_in    = ST_FINISH;
            end
            acc_in = unit_y;
         end

         ST_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register and running value update together
   always_comb begin
      run_in       = run_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         run_in       = fin_res.packed_value;
         rsp_data_in  = fin_res;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      ls_ff        <= ls_in;
      lo_ff        <= lo_in;
      mode_ff      <= mode_in;
      opnd_ff      <= opnd_in;
      digit_ff     <= digit_in;
      run_long_ff  <= run_long_in;
      opnd_long_ff <= opnd_long_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // A pending result always matches the running value it came from
   a_rsp_tracks_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.packed_value == run_ff))
      else $error("pending result differs from running value");

   // Long-form flag agrees with the value
   a_flag_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.is_length_only == (rsp_data_ff.packed_value > CUT)))
      else $error("is_length_only inconsistent with packed_value");

   // Digit shifting only happens when both sides are short
   a_shift_short: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (!run_long_ff && !opnd_long_ff))
      else $error("digit shift with a long-form side");

   // Digit counts never pass the length limit
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_CNT_RUN) || (state_ff == ST_CNT_OPND)) |->
      ((ls_ff <= CNT_W'(LEN_LIMIT)) && (lo_ff <= CNT_W'(LEN_LIMIT))))
      else $error("digit count beyond length limit");

   // An accepted transaction always leaves idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ST_IDLE))
      else $error("sequencer stayed idle after accept");
`endif

endmodule
